// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/icfpr_pkg.sv =====
package icfpr_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLK_W   = 25;
    localparam int unsigned LANES   = 4;

    localparam logic [31:0] PHYS_MASK     = 32'h1FFF_FFFF;
    localparam logic [9:0]  BIOS_WINDOW   = 10'h3F8;
    localparam logic [2:0]  SEG_MAX       = 3'd4;
    localparam logic [7:0]  UNCACHED_WAIT = 8'd6;

    localparam logic OP_FETCH = 1'b0;
    localparam logic OP_INVAL = 1'b1;

    localparam logic [1:0] CFG_CACHE_ENABLE = 2'd0;
    localparam logic [1:0] CFG_REFILL_FOUR  = 2'd1;
    localparam logic [1:0] CFG_BIOS_DELAY   = 2'd2;
    localparam logic [1:0] CFG_COM_DELAY    = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic        op;
        logic [31:0] address;
        logic [31:0] mem_word0;
        logic [31:0] mem_word1;
        logic [31:0] mem_word2;
        logic [31:0] mem_word3;
    } t_in_word;

    typedef struct packed {
        logic [31:0] instruction;
        logic        hit;
        logic        uncached;
        logic [2:0]  words_filled;
        logic [7:0]  wait_cycles;
    } t_out_word;

    typedef struct packed {
        logic       miss;
        logic [1:0] word;
        logic [1:0] last;
    } t_lane_ctl;

endpackage

// ===== hdl/icfpr_ram.sv =====
module icfpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/icfpr_lane.sv =====
module icfpr_lane #(
    parameter int LINES   = 256,
    parameter int LANE_ID = 0
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(LINES)-1:0] i_raddr,
    input  logic [$clog2(LINES)-1:0] i_waddr,
    input  icfpr_pkg::t_lane_ctl     i_ctl,
    input  logic [31:0]              i_mem_word,
    output logic                     o_fill,
    output logic [31:0]              o_word
);

    localparam logic [1:0] LANE_SEL = LANE_ID[1:0];

    logic [31:0] rdata;

    assign o_fill = i_ctl.miss && (LANE_SEL >= i_ctl.word) && (LANE_SEL <= i_ctl.last);

    icfpr_ram #(
        .WIDTH(icfpr_pkg::WORD_W),
        .DEPTH(LINES)
    ) u_words (
        .i_clk  (i_clk),
        .i_we   (o_fill),
        .i_waddr(i_waddr),
        .i_wdata(i_mem_word),
        .i_re   (i_re),
        .i_raddr(i_raddr),
        .o_rdata(rdata)
    );

    assign o_word = (i_ctl.word == LANE_SEL) ? rdata : '0;

endmodule

// ===== hdl/icfpr_bus_timing.sv =====
module icfpr_bus_timing (
    input  logic [12:0] i_bios_delay,
    input  logic [15:0] i_com_delay,
    output logic [7:0]  o_cycles
);

    logic signed [9:0] c0;
    logic signed [9:0] c2;
    logic signed [9:0] c3;
    logic signed [9:0] acc;
    logic signed [9:0] mins;
    logic signed [9:0] base;
    logic signed [9:0] first_a;
    logic signed [9:0] first_b;
    logic signed [9:0] first_c;
    logic signed [9:0] seq_a;
    logic signed [9:0] seq_b;
    logic signed [9:0] total;

    always_comb begin
        c0      = signed'({6'd0, i_com_delay[3:0]});
        c2      = signed'({6'd0, i_com_delay[11:8]});
        c3      = signed'({6'd0, i_com_delay[15:12]});
        acc     = signed'({6'd0, i_bios_delay[7:4]}) + 10'sd1;
        mins    = i_bios_delay[11] ? c3 : 10'sd0;
        base    = (i_bios_delay[8] ? (c0 - 10'sd1) : 10'sd0)
                + (i_bios_delay[10] ? c2 : 10'sd0);
        first_a = (base < 10'sd6) ? (base + 10'sd1) : base;
        first_b = first_a + acc + 10'sd2;
        first_c = (first_b < (mins + 10'sd6)) ? (mins + 10'sd6) : first_b;
        seq_a   = base + acc + 10'sd2;
        seq_b   = (seq_a < (mins + 10'sd2)) ? (mins + 10'sd2) : seq_a;
        total   = first_c + (i_bios_delay[12] ? seq_b : (seq_b + (seq_b <<< 1)));
        priority if (total < 10'sd0) begin
            o_cycles = 8'd0;
        end else if (total > 10'sd255) begin
            o_cycles = 8'd255;
        end else begin
            o_cycles = total[7:0];
        end
    end

endmodule

// ===== hdl/icache_fetch_with_partial_refill.sv =====
// Channel   Direction  Handshake                       Word
// command   in         i_start, o_busy                 i_word   (t_in_word)
// result    out        o_done (one-cycle strobe)       o_result (t_out_word)
// config    in         i_cfg_valid, o_cfg_ready        i_cfg_index, i_cfg_data
//
// Each item is handled in order: the registered read of the tag/valid RAM and
// the four word lanes, then tag compare, merge and write-back.
// o_done is registered from the lookup state entered at the accepting edge;
// o_busy is low during the strobe, so the next item may be accepted as it ends.
// After reset a clearing pass writes zero tags and valid bits to every line
// with o_busy high; config writes are taken throughout.
// The receiver cannot stall: each result is shown for exactly one cycle.
// LINES must be a power of two in 16..1024.
`include "assert_macros.svh"

module icache_fetch_with_partial_refill #(
    parameter int LINES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  icfpr_pkg::t_in_word   i_word,
    output logic                  o_done,
    output icfpr_pkg::t_out_word  o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    localparam int IDX_W = $clog2(LINES);
    localparam int TAG_W = icfpr_pkg::BLK_W - IDX_W;
    localparam int TV_W  = TAG_W + icfpr_pkg::LANES;

    icfpr_pkg::t_state    r_state;
    icfpr_pkg::t_state    n_state;
    logic [IDX_W-1:0]     r_clr_cnt;
    icfpr_pkg::t_in_word  r_req;
    icfpr_pkg::t_out_word r_out;
    icfpr_pkg::t_out_word n_out;
    logic                 r_done;
    logic                 r_cache_enable;
    logic                 r_refill_four;
    logic [12:0]          r_bios_delay;
    logic [15:0]          r_com_delay;

    logic                 busy;
    logic                 clearing;
    logic                 lookup;
    logic                 accept;

    logic [31:0]          phys;
    logic [IDX_W-1:0]     idx;
    logic [TAG_W-1:0]     tag;
    logic [1:0]           word;
    logic [IDX_W-1:0]     rd_idx;
    logic [TV_W-1:0]      tv_rd;
    logic [TAG_W-1:0]     tag_rd;
    logic [3:0]           valid_rd;
    logic [3:0]           word_dec;
    logic                 tag_match;
    logic                 is_inv;
    logic                 bypass;
    logic                 hit;
    logic                 miss;
    logic [2:0]           last_sum;
    icfpr_pkg::t_lane_ctl lane_ctl;
    logic [3:0]           fill_mask;
    logic [31:0]          lane_word [icfpr_pkg::LANES];
    logic [31:0]          mem_w [icfpr_pkg::LANES];
    logic [31:0]          cached_word;
    logic [3:0]           valid_new;
    logic                 tv_we;
    logic [IDX_W-1:0]     tv_waddr;
    logic [TV_W-1:0]      tv_wdata;
    logic [7:0]           bios_cycles;
    logic [7:0]           unc_wait;

    // FSM next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            icfpr_pkg::ST_CLEAR: begin
                if (r_clr_cnt == IDX_W'(LINES - 1)) begin
                    n_state = icfpr_pkg::ST_IDLE;
                end
            end
            icfpr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = icfpr_pkg::ST_LOOKUP;
                end
            end
            icfpr_pkg::ST_LOOKUP: begin
                n_state = icfpr_pkg::ST_IDLE;
            end
            default: begin
                n_state = icfpr_pkg::ST_CLEAR;
            end
        endcase
    end

    // FSM outputs
    always_comb begin
        busy     = 1'b1;
        clearing = 1'b0;
        lookup   = 1'b0;
        unique case (r_state)
            icfpr_pkg::ST_CLEAR:  clearing = 1'b1;
            icfpr_pkg::ST_IDLE:   busy     = 1'b0;
            icfpr_pkg::ST_LOOKUP: lookup   = 1'b1;
            default:              clearing = 1'b0;
        endcase
    end

    assign o_busy      = busy;
    assign accept      = i_start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= icfpr_pkg::ST_CLEAR;
            r_clr_cnt      <= '0;
            r_done         <= 1'b0;
            r_cache_enable <= 1'b0;
            r_refill_four  <= 1'b0;
            r_bios_delay   <= '0;
            r_com_delay    <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= lookup;
            if (clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    icfpr_pkg::CFG_CACHE_ENABLE: r_cache_enable <= i_cfg_data[0];
                    icfpr_pkg::CFG_REFILL_FOUR:  r_refill_four  <= i_cfg_data[0];
                    icfpr_pkg::CFG_BIOS_DELAY:   r_bios_delay   <= i_cfg_data[12:0];
                    icfpr_pkg::CFG_COM_DELAY:    r_com_delay    <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_word;
        end
        if (lookup) begin
            r_out <= n_out;
        end
    end

    assign rd_idx = i_word.address[IDX_W+3:4];

    assign phys     = r_req.address & icfpr_pkg::PHYS_MASK;
    assign idx      = phys[IDX_W+3:4];
    assign tag      = phys[28:IDX_W+4];
    assign word     = phys[3:2];
    assign tag_rd   = tv_rd[TV_W-1:4];
    assign valid_rd = tv_rd[3:0];
    assign word_dec = 4'b0001 << word;

    assign is_inv    = (r_req.op == icfpr_pkg::OP_INVAL);
    assign bypass    = !r_cache_enable || (r_req.address[31:29] > icfpr_pkg::SEG_MAX);
    assign tag_match = (tag_rd == tag);
    assign hit       = tag_match && ((valid_rd & word_dec) != 4'b0000);
    assign miss      = lookup && !is_inv && !bypass && !hit;

    assign last_sum      = {1'b0, word} + (r_refill_four ? 3'd3 : 3'd1);
    assign lane_ctl.miss = miss;
    assign lane_ctl.word = word;
    assign lane_ctl.last = (last_sum > 3'd3) ? 2'd3 : last_sum[1:0];

    assign mem_w[0] = r_req.mem_word0;
    assign mem_w[1] = r_req.mem_word1;
    assign mem_w[2] = r_req.mem_word2;
    assign mem_w[3] = r_req.mem_word3;

    for (genvar g = 0; g < icfpr_pkg::LANES; g++) begin : g_lane
        icfpr_lane #(
            .LINES  (LINES),
            .LANE_ID(g)
        ) u_lane (
            .i_clk     (i_clk),
            .i_re      (accept),
            .i_raddr   (rd_idx),
            .i_waddr   (idx),
            .i_ctl     (lane_ctl),
            .i_mem_word(mem_w[g]),
            .o_fill    (fill_mask[g]),
            .o_word    (lane_word[g])
        );
    end

    assign cached_word = lane_word[0] | lane_word[1] | lane_word[2] | lane_word[3];

    always_comb begin
        if (is_inv) begin
            valid_new = valid_rd & ~word_dec;
        end else begin
            valid_new = (tag_match ? valid_rd : 4'b0000) | fill_mask;
        end
    end

    always_comb begin
        if (clearing) begin
            tv_we    = 1'b1;
            tv_waddr = r_clr_cnt;
            tv_wdata = '0;
        end else begin
            tv_we    = lookup && (is_inv || miss);
            tv_waddr = idx;
            tv_wdata = {(is_inv ? tag_rd : tag), valid_new};
        end
    end

    icfpr_ram #(
        .WIDTH(TV_W),
        .DEPTH(LINES)
    ) u_tag_valid (
        .i_clk  (i_clk),
        .i_we   (tv_we),
        .i_waddr(tv_waddr),
        .i_wdata(tv_wdata),
        .i_re   (accept),
        .i_raddr(rd_idx),
        .o_rdata(tv_rd)
    );

    icfpr_bus_timing u_bus_timing (
        .i_bios_delay(r_bios_delay),
        .i_com_delay (r_com_delay),
        .o_cycles    (bios_cycles)
    );

    assign unc_wait = (phys[28:19] == icfpr_pkg::BIOS_WINDOW) ? bios_cycles
                                                              : icfpr_pkg::UNCACHED_WAIT;

    always_comb begin
        n_out = '0;
        priority if (is_inv) begin
            n_out = '0;
        end else if (bypass) begin
            n_out.instruction = mem_w[word];
            n_out.uncached    = 1'b1;
            n_out.wait_cycles = unc_wait;
        end else if (hit) begin
            n_out.instruction = cached_word;
            n_out.hit         = 1'b1;
        end else begin
            n_out.instruction  = mem_w[word];
            n_out.words_filled = 3'(fill_mask[0]) + 3'(fill_mask[1])
                               + 3'(fill_mask[2]) + 3'(fill_mask[3]);
            n_out.wait_cycles  = {5'd0, n_out.words_filled};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    `ASSERT_NEXT(a_lookup_done, i_clk, i_rst_n, r_state == icfpr_pkg::ST_LOOKUP, o_done)
    `ASSERT_IMPLY(a_clear_busy, i_clk, i_rst_n, r_state == icfpr_pkg::ST_CLEAR, o_busy)
    `ASSERT_IMPLY(a_hit_no_fill, i_clk, i_rst_n, o_done && o_result.hit,
                  !o_result.uncached && (o_result.words_filled == 3'd0))
    `ASSERT_IMPLY(a_fill_wait, i_clk, i_rst_n, o_done && (o_result.words_filled != 3'd0),
                  o_result.wait_cycles == {5'd0, o_result.words_filled})
    `ASSERT_IMPLY(a_fill_range, i_clk, i_rst_n, lookup, $countones(fill_mask) <= 3'd4)

endmodule

// ===== verif/icache_fetch_with_partial_refill_tb.sv =====
module icache_fetch_with_partial_refill_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic                drain;
        icfpr_pkg::t_in_word cmd;
    } t_fetch_cmd;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    logic                 o_busy;
    icfpr_pkg::t_in_word  i_word      = '0;
    logic                 o_done;
    icfpr_pkg::t_out_word o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;

    t_fetch_cmd           fetch_cmd_q[$];
    icfpr_pkg::t_out_word fetch_results_q[$];
    int         idle_pct   = 0;
    int         cycle_cnt  = 0;
    int         mismatches = 0;
    int         results_seen = 0;

    // cache image and registers as the fetch unit should hold them
    logic [16:0] tag_m   [256] = '{default: '0};
    logic [3:0]  valid_m [256] = '{default: '0};
    logic [31:0] words_m [1024] = '{default: '0};
    logic        en_m   = 1'b0;
    logic        r4_m   = 1'b0;
    logic [12:0] bios_m = '0;
    logic [15:0] com_m  = '0;

    int n_hit = 0, n_refill = 0, n_unc = 0, n_bios = 0, n_inval = 0, n_regw = 0;

    icache_fetch_with_partial_refill #(
        .LINES(256)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_word      (i_word),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] bios_read_wait();
        int c0, c2, c3, acc, first, seq, mins, units, total;
        c0 = int'(com_m[3:0]);
        c2 = int'(com_m[11:8]);
        c3 = int'(com_m[15:12]);
        acc = int'(bios_m[7:4]) + 1;
        first = 0;
        seq = 0;
        mins = 0;
        if (bios_m[8]) begin
            first += c0 - 1;
            seq += c0 - 1;
        end
        if (bios_m[10]) begin
            first += c2;
            seq += c2;
        end
        if (bios_m[11]) begin
            mins = c3;
        end
        if (first < 6) begin
            first += 1;
        end
        first += acc + 2;
        seq += acc + 2;
        if (first < mins + 6) begin
            first = mins + 6;
        end
        if (seq < mins + 2) begin
            seq = mins + 2;
        end
        units = bios_m[12] ? 2 : 4;
        total = first + (units - 1) * seq;
        if (total < 0) begin
            total = 0;
        end
        if (total > 255) begin
            total = 255;
        end
        return 8'(total);
    endfunction

    function automatic logic [7:0] bus_wait(logic [28:0] phys);
        if (phys >= 29'h080_0000 && phys[28:19] == icfpr_pkg::BIOS_WINDOW) begin
            n_bios++;
            return bios_read_wait();
        end
        return icfpr_pkg::UNCACHED_WAIT;
    endfunction

    function automatic icfpr_pkg::t_out_word icache_predict(icfpr_pkg::t_in_word w);
        icfpr_pkg::t_out_word r;
        logic [28:0]          phys;
        logic [7:0]           line;
        logic [16:0]          tag;
        logic [1:0]           wd;
        logic [3:0][31:0]     mem;
        int                   last;
        r = '0;
        phys = w.address[28:0];
        line = phys[11:4];
        tag = phys[28:12];
        wd = phys[3:2];
        mem = {w.mem_word3, w.mem_word2, w.mem_word1, w.mem_word0};
        if (w.op == icfpr_pkg::OP_INVAL) begin
            valid_m[line][wd] = 1'b0;
            n_inval++;
        end else if (!en_m || w.address[31:29] > icfpr_pkg::SEG_MAX) begin
            r.instruction = mem[wd];
            r.uncached = 1'b1;
            r.wait_cycles = bus_wait(phys);
            n_unc++;
        end else if (tag_m[line] == tag && valid_m[line][wd]) begin
            r.instruction = words_m[{line, wd}];
            r.hit = 1'b1;
            n_hit++;
        end else begin
            if (tag_m[line] != tag) begin
                tag_m[line] = tag;
                valid_m[line] = '0;
            end
            last = int'(wd) + (r4_m ? 3 : 1);
            if (last > 3) begin
                last = 3;
            end
            for (int k = int'(wd); k <= last; k++) begin
                words_m[{line, 2'(k)}] = mem[k];
                valid_m[line][k] = 1'b1;
                r.words_filled++;
            end
            r.wait_cycles = 8'(r.words_filled);
            r.instruction = mem[wd];
            n_refill++;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch on result %0d, %s: got %h, want %h",
                     results_seen, field, got, want);
        end
        mismatches++;
    endtask

    task automatic check_result(icfpr_pkg::t_out_word got, icfpr_pkg::t_out_word want);
        if (got.instruction !== want.instruction)
            report_mismatch("instruction", got.instruction, want.instruction);
        if (got.hit !== want.hit)
            report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.uncached !== want.uncached)
            report_mismatch("uncached", 32'(got.uncached), 32'(want.uncached));
        if (got.words_filled !== want.words_filled)
            report_mismatch("words_filled", 32'(got.words_filled), 32'(want.words_filled));
        if (got.wait_cycles !== want.wait_cycles)
            report_mismatch("wait_cycles", 32'(got.wait_cycles), 32'(want.wait_cycles));
    endtask

    always @(posedge i_clk) begin
        logic settled;
        settled = fetch_results_q.size() == 0 && !o_done && !(i_start && !o_busy);
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || !o_busy) begin
            if (fetch_cmd_q.size() > 0 && $urandom_range(99) >= idle_pct &&
                !(fetch_cmd_q[0].drain && !settled)) begin
                i_word <= fetch_cmd_q[0].cmd;
                void'(fetch_cmd_q.pop_front());
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        icfpr_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_done) begin
                if (fetch_results_q.size() == 0) begin
                    report_mismatch("unexpected result", o_result.instruction, 32'h0);
                end else begin
                    want = fetch_results_q.pop_front();
                    check_result(o_result, want);
                end
                results_seen++;
            end
            if (i_start && !o_busy) begin
                fetch_results_q.push_back(icache_predict(i_word));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                n_regw++;
                case (i_cfg_index)
                    icfpr_pkg::CFG_CACHE_ENABLE: en_m = i_cfg_data[0];
                    icfpr_pkg::CFG_REFILL_FOUR:  r4_m = i_cfg_data[0];
                    icfpr_pkg::CFG_BIOS_DELAY:   bios_m = i_cfg_data[12:0];
                    icfpr_pkg::CFG_COM_DELAY:    com_m = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [127:0] rand_block();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    task automatic queue_cmd(logic op, logic [31:0] addr, logic [127:0] mem, logic drain);
        t_fetch_cmd c;
        c.drain = drain;
        c.cmd.op = op;
        c.cmd.address = addr;
        {c.cmd.mem_word3, c.cmd.mem_word2, c.cmd.mem_word1, c.cmd.mem_word0} = mem;
        fetch_cmd_q.push_back(c);
    endtask

    task automatic cfg_put(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic en, logic r4, logic [12:0] bios, logic [15:0] com);
        cfg_put(icfpr_pkg::CFG_CACHE_ENABLE, {15'($urandom()), en});
        cfg_put(icfpr_pkg::CFG_REFILL_FOUR, {15'($urandom()), r4});
        cfg_put(icfpr_pkg::CFG_BIOS_DELAY, {3'($urandom()), bios});
        cfg_put(icfpr_pkg::CFG_COM_DELAY, com);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (fetch_cmd_q.size() != 0 || i_start || fetch_results_q.size() != 0);
    endtask

    function automatic logic [31:0] pool_addr();
        logic [16:0] tag;
        logic [7:0]  line;
        case ($urandom_range(7))
            0, 1, 2, 3: tag = 17'($urandom_range(3));
            4:          tag = 17'h1FC00;
            5:          tag = 17'h1FFFF;
            default:    tag = 17'($urandom());
        endcase
        line = ($urandom_range(9) < 8) ? 8'($urandom_range(7)) : 8'($urandom());
        return {3'($urandom_range(4)), tag, line, 4'($urandom())};
    endfunction

    function automatic logic [31:0] any_addr();
        int r;
        r = $urandom_range(99);
        if (r < 62) begin
            return pool_addr();
        end else if (r < 80) begin
            return {3'($urandom()), icfpr_pkg::BIOS_WINDOW, 19'($urandom())};
        end
        return $urandom();
    endfunction

    task automatic queue_random(int n);
        logic [31:0] base;
        int          left;
        left = n;
        while (left > 0) begin
            if (left >= 4 && $urandom_range(3) == 0) begin
                base = pool_addr();
                for (int k = 0; k < 4; k++) begin
                    queue_cmd(icfpr_pkg::OP_FETCH, {base[31:4], 2'(k), base[1:0]},
                              rand_block(), 1'b0);
                end
                left -= 4;
            end else begin
                queue_cmd(($urandom_range(99) < 12) ? icfpr_pkg::OP_INVAL
                                                    : icfpr_pkg::OP_FETCH,
                          any_addr(), rand_block(), $urandom_range(99) < 2);
                left--;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_0000, '0, 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'hBFC0_0000, '1, 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h1FC8_0000, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'hFFFF_FFFF, '1, 1'b0);
        queue_cmd(icfpr_pkg::OP_INVAL, 32'h0000_0000, rand_block(), 1'b0);
        wait_drained();

        set_config(1'b1, 1'b0, 13'h1FFF, 16'hFFFF);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_0000, '1, 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_0004, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_0008, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_000C, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_100C, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_0000, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_INVAL, 32'h0000_0004, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h8000_0000, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_0004, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'hA000_0004, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'hBFC7_FFFC, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h9FC0_0000, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h1FFF_FFFC, '1, 1'b0);
        queue_cmd(icfpr_pkg::OP_INVAL, 32'hE000_0000, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_0000, '0, 1'b0);
        wait_drained();

        set_config(1'b1, 1'b1, 13'h1000, 16'h0F0F);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_2000, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_2008, rand_block(), 1'b1);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h0000_3004, rand_block(), 1'b0);
        queue_cmd(icfpr_pkg::OP_FETCH, 32'h1FFF_FFF0, rand_block(), 1'b0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(1'b1, 1'b0, 13'h0000, 16'h0000);
                1: set_config(1'b1, 1'b1, 13'($urandom()), 16'($urandom()));
                2: set_config(1'b0, 1'b1, 13'($urandom()), 16'($urandom()));
                3: set_config(1'b1, 1'b0, 13'h1FFF, 16'hFFFF);
                4: set_config(1'b1, 1'b1, 13'($urandom()), 16'($urandom()));
                default: set_config(1'($urandom()), 1'($urandom()), 13'($urandom()), 16'h0);
            endcase
            idle_pct = (ph < 2) ? 7 : (ph < 4) ? 65 : 0;
            queue_random(92);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (fetch_results_q.size() != 0) begin
            report_mismatch("results never returned", 32'(fetch_results_q.size()), 32'h0);
        end
        $display("covered %0d commands: %0d hits, %0d refills, %0d uncached (%0d BIOS timed)",
                 n_hit + n_refill + n_unc + n_inval, n_hit, n_refill, n_unc, n_bios);
        $display("covered %0d invalidates and %0d register writes over 9 settings",
                 n_inval, n_regw);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
